[sv/nte_pkg.sv]
// shared constants, codes, types and name helper for the name table engine
package nte_pkg;

   // table geometry
   localparam int unsigned NUM_ENTRIES = 16;
   localparam int unsigned NAME_BYTES  = 8;
   localparam int unsigned IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   // field widths
   localparam int unsigned NAME_W = 64;
   localparam int unsigned FUNC_W = 3;
   localparam int unsigned STAT_W = 2;
   localparam int unsigned POS_W  = 4;
   localparam int unsigned RIDX_W = 4;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
   localparam logic [FUNC_W-1:0] FN_MODIFY = 3'd1;
   localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
   localparam logic [FUNC_W-1:0] FN_SORT   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] ST_INVALID   = 2'd3;

   // access bundle from the controller to the table
   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [NAME_W-1:0] wdata;
      logic              re;
      logic [IDX_W-1:0]  raddr;
   } tbl_req_type;

   // cut a name at its first zero byte and at NAME_BYTES bytes
   function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] v);
      logic [NAME_W-1:0] o;
      logic              live;
      o    = '0;
      live = 1'b1;
      for (int b = 0; b < 8; b++) begin
         if (b >= int'(NAME_BYTES) || v[NAME_W-1-8*b -: 8] == 8'd0) begin
            live = 1'b0;
         end
         if (live) begin
            o[NAME_W-1-8*b -: 8] = v[NAME_W-1-8*b -: 8];
         end
      end
      return o;
   endfunction

endpackage

[sv/nte_ram.sv]
// generic single-clock ram, one write port and one registered read port
module nte_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/nte_table.sv]
// name storage: ram plus per-entry written flags, unwritten entries read as empty
module nte_table (
   input  logic                       clock,
   input  logic                       reset,
   input  nte_pkg::tbl_req_type       tbl_req,
   output logic [nte_pkg::NAME_W-1:0] rd_name
);
   import nte_pkg::*;

   logic [NUM_ENTRIES-1:0] vld_ff;
   logic [NUM_ENTRIES-1:0] vld_in;
   logic                   vld_rd_ff;
   logic [NAME_W-1:0]      ram_q;

   nte_ram #(
      .WIDTH (NAME_W),
      .DEPTH (NUM_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (tbl_req.we),
      .wr_addr (tbl_req.waddr),
      .wr_data (tbl_req.wdata),
      .rd_en   (tbl_req.re),
      .rd_addr (tbl_req.raddr),
      .rd_data (ram_q)
   );

   // written flags, cleared at reset so the table starts empty
   always_comb begin
      vld_in = vld_ff;
      if (tbl_req.we) begin
         vld_in[tbl_req.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // flag is registered alongside the ram read, so both arrive together
   always_ff @(posedge clock) begin
      if (tbl_req.re) begin
         vld_rd_ff <= vld_ff[tbl_req.raddr];
      end
   end

   assign rd_name = vld_rd_ff ? ram_q : '0;

endmodule

[sv/name_table_engine_unit.sv]
// name table engine top: command sequencer around the name table memory
//
//   channel  | dir | ports                                         | handshake
//   request  | in  | req_func, req_key_name, req_replacement_name, | req_valid / req_stall
//            |     | req_read_index                                |
//   response | out | rsp_status, rsp_position, rsp_entry_name      | rsp_valid / rsp_stall
//
// one request at a time; the table memory has one read and one write port per cycle.
// add/modify/delete scan the slots one per cycle and stop at the first match.
// read issues one table read and takes its result in a wait state; sort runs bubble
// passes, up to NUM_ENTRIES of them, repeating until a pass makes no swap.
// reset clears the per-entry written flags at once: no clearing pass, ready next cycle.
// a new request is taken while a response waits under rsp_stall; it completes when
// the response register frees up.
module name_table_engine_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [nte_pkg::FUNC_W-1:0] req_func,
   input  logic [nte_pkg::NAME_W-1:0] req_key_name,
   input  logic [nte_pkg::NAME_W-1:0] req_replacement_name,
   input  logic [nte_pkg::RIDX_W-1:0] req_read_index,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [nte_pkg::STAT_W-1:0] rsp_status,
   output logic [nte_pkg::POS_W-1:0]  rsp_position,
   output logic [nte_pkg::NAME_W-1:0] rsp_entry_name
);
   import nte_pkg::*;

   localparam int unsigned CMP_W = (RIDX_W > IDX_W) ? RIDX_W + 1 : IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_ENTRIES - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DISP = 3'd1;
   localparam logic [2:0] S_SRCH = 3'd2;
   localparam logic [2:0] S_RDWT = 3'd3;
   localparam logic [2:0] S_SORT = 3'd4;
   localparam logic [2:0] S_SEND = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [NAME_W-1:0] key_ff, key_in;
   logic [NAME_W-1:0] repl_ff, repl_in;
   logic [RIDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0]  iss_addr_ff, iss_addr_in;
   logic              iss_on_ff, iss_on_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic [NAME_W-1:0] cur_ff, cur_in;
   logic              swap_ff, swap_in;
   logic [STAT_W-1:0] res_stat_ff, res_stat_in;
   logic [POS_W-1:0]  res_pos_ff, res_pos_in;
   logic [NAME_W-1:0] res_entry_ff, res_entry_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [NAME_W-1:0] rsp_entry_ff, rsp_entry_in;

   tbl_req_type       tbl_req;
   logic [NAME_W-1:0] rd_name;
   logic [NAME_W-1:0] tgt_name;
   logic [NAME_W-1:0] new_name;
   logic              idx_oor;
   logic              req_take;

   nte_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_name (rd_name)
   );

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // search key and the value a hit writes back
   always_comb begin
      tgt_name = key_ff;
      new_name = '0;
      unique case (func_ff)
         FN_ADD: begin
            tgt_name = '0;
            new_name = key_ff;
         end
         FN_MODIFY: new_name = repl_ff;
         default:   new_name = '0;
      endcase
   end

   assign idx_oor = CMP_W'(idx_ff) >= CMP_W'(NUM_ENTRIES);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      repl_in      = repl_ff;
      idx_in       = idx_ff;
      iss_addr_in  = iss_addr_ff;
      iss_on_in    = iss_on_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      cur_in       = cur_ff;
      swap_in      = swap_ff;
      res_stat_in  = res_stat_ff;
      res_pos_in   = res_pos_ff;
      res_entry_in = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_entry_in  = rsp_entry_ff;
      tbl_req       = '0;

      // sequential slot reads for scans and sort passes
      if ((state_ff == S_SRCH || state_ff == S_SORT) && iss_on_ff) begin
         tbl_req.re    = 1'b1;
         tbl_req.raddr = iss_addr_ff;
         chk_vld_in    = 1'b1;
         chk_idx_in    = iss_addr_ff;
         if (iss_addr_ff == LAST) begin
            iss_on_in = 1'b0;
         end else begin
            iss_addr_in = iss_addr_ff + 1'b1;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               func_in  = req_func;
               key_in   = norm_name(req_key_name);
               repl_in  = norm_name(req_replacement_name);
               idx_in   = req_read_index;
               state_in = S_DISP;
            end
         end

         // decode the request
         S_DISP: begin
            res_stat_in  = ST_OK;
            res_pos_in   = '0;
            res_entry_in = '0;
            iss_addr_in  = '0;
            unique case (func_ff)
               FN_ADD, FN_DELETE: begin
                  if (key_ff == '0) begin
                     res_stat_in = ST_INVALID;
                     state_in    = S_DONE;
                  end else begin
                     iss_on_in = 1'b1;
                     state_in  = S_SRCH;
                  end
               end
               FN_MODIFY: begin
                  if (key_ff == '0 || repl_ff == '0) begin
                     res_stat_in = ST_INVALID;
                     state_in    = S_DONE;
                  end else begin
                     iss_on_in = 1'b1;
                     state_in  = S_SRCH;
                  end
               end
               FN_SORT: begin
                  iss_on_in = 1'b1;
                  swap_in   = 1'b0;
                  state_in  = S_SORT;
               end
               FN_READ: begin
                  if (idx_oor) begin
                     res_stat_in = ST_NOT_FOUND;
                     state_in    = S_DONE;
                  end else begin
                     tbl_req.re    = 1'b1;
                     tbl_req.raddr = IDX_W'(idx_ff);
                     state_in      = S_RDWT;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end

         // first-match scan, write back on a hit
         S_SRCH: begin
            if (chk_vld_ff) begin
               if (rd_name == tgt_name) begin
                  tbl_req.we    = 1'b1;
                  tbl_req.waddr = chk_idx_ff;
                  tbl_req.wdata = new_name;
                  res_pos_in    = POS_W'(chk_idx_ff);
                  iss_on_in     = 1'b0;
                  chk_vld_in    = 1'b0;
                  state_in      = S_DONE;
               end else if (chk_idx_ff == LAST) begin
                  res_stat_in = (func_ff == FN_ADD) ? ST_FULL : ST_NOT_FOUND;
                  state_in    = S_DONE;
               end
            end
         end

         S_RDWT: begin
            res_entry_in = rd_name;
            res_pos_in   = POS_W'(idx_ff);
            state_in     = S_DONE;
         end

         // bubble pass: carry the larger name upward, write the smaller one back
         S_SORT: begin
            if (chk_vld_ff) begin
               if (chk_idx_ff == '0) begin
                  cur_in = rd_name;
               end else begin
                  tbl_req.we    = 1'b1;
                  tbl_req.waddr = chk_idx_ff - 1'b1;
                  if (cur_ff > rd_name) begin
                     tbl_req.wdata = rd_name;
                     swap_in       = 1'b1;
                  end else begin
                     tbl_req.wdata = cur_ff;
                     cur_in        = rd_name;
                  end
               end
               if (chk_idx_ff == LAST) begin
                  state_in = S_SEND;
               end
            end
         end

         // close the pass, run another if anything moved
         S_SEND: begin
            tbl_req.we    = 1'b1;
            tbl_req.waddr = LAST;
            tbl_req.wdata = cur_ff;
            if (swap_ff) begin
               swap_in     = 1'b0;
               iss_on_in   = 1'b1;
               iss_addr_in = '0;
               state_in    = S_SORT;
            end else begin
               state_in = S_DONE;
            end
         end

         // hand the result to the response register
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_stat_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_entry_in  = res_entry_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iss_on_ff    <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_on_ff    <= iss_on_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      repl_ff       <= repl_in;
      idx_ff        <= idx_in;
      iss_addr_ff   <= iss_addr_in;
      chk_idx_ff    <= chk_idx_in;
      cur_ff        <= cur_in;
      swap_ff       <= swap_in;
      res_stat_ff   <= res_stat_in;
      res_pos_ff    <= res_pos_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_entry_name = rsp_entry_ff;

`ifndef SYNTHESIS
   // failed responses carry no position and no name
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_position == '0 && rsp_entry_name == '0))
      else $error("failed response with nonzero position or name");

   // an accepted request keeps the sequencer busy next cycle
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer idle");

   // a read and a write never hit the same slot in one cycle
   a_no_clash: assert property (@(posedge clock) disable iff (reset)
      (tbl_req.we && tbl_req.re) |-> (tbl_req.waddr != tbl_req.raddr))
      else $error("table read and write to the same slot");
`endif

endmodule
